FILE: sv/drgm_pkg.sv
// Package with the beat types, group state type and constants of the date range gap merger.
package drgm_pkg;

  localparam int unsigned TagW   = 32;
  localparam int unsigned DayW   = 32;
  localparam int unsigned GapW   = 20;
  localparam int unsigned FifoD  = 3;
  localparam int unsigned PtrW   = $clog2(FifoD);
  localparam int unsigned CntW   = $clog2(FifoD + 1);

  typedef struct packed {
    logic signed [DayW-1:0] start_day;
    logic signed [DayW-1:0] end_day;
    logic [TagW-1:0]        start_tag;
    logic [TagW-1:0]        end_tag;
    logic                   last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DayW-1:0] merged_start;
    logic signed [DayW-1:0] merged_end;
    logic [TagW-1:0]        merged_start_tag;
    logic [TagW-1:0]        merged_end_tag;
    logic                   last_out;
  } out_item_t;

  typedef struct packed {
    logic                   open;
    logic signed [DayW-1:0] first_day;
    logic signed [DayW-1:0] last_day;
    logic [TagW-1:0]        first_tag;
    logic [TagW-1:0]        last_tag;
  } group_t;

endpackage

FILE: sv/drgm_merge_core.sv
// Combinational merge step: folds one range into the open group and forms up to two results.
module drgm_merge_core (
  input  drgm_pkg::group_t    grp_i,
  input  drgm_pkg::in_item_t  item_i,
  input  logic [drgm_pkg::GapW-1:0] gap_i,
  output drgm_pkg::group_t    grp_o,
  output drgm_pkg::out_item_t res0_o,
  output drgm_pkg::out_item_t res1_o,
  output logic [1:0]          num_o
);
  import drgm_pkg::*;

  logic signed [DayW+1:0] diff;
  logic signed [DayW+1:0] limit;
  logic                   close_grp;
  logic                   grows;
  group_t                 new_grp;
  out_item_t              old_res;
  out_item_t              upd_res;

  // The distance is formed with two spare bits so it can never wrap.
  assign diff  = {{2{item_i.start_day[DayW-1]}}, item_i.start_day}
               - {{2{grp_i.last_day[DayW-1]}}, grp_i.last_day};
  assign limit = $signed({{(DayW+2-GapW){1'b0}}, gap_i} + (DayW+2)'(1));

  assign close_grp = grp_i.open && (diff > limit);
  assign grows     = item_i.end_day > grp_i.last_day;

  always_comb begin
    new_grp.open      = 1'b1;
    new_grp.first_day = item_i.start_day;
    new_grp.last_day  = item_i.end_day;
    new_grp.first_tag = item_i.start_tag;
    new_grp.last_tag  = item_i.end_tag;

    grp_o = grp_i;
    if (!grp_i.open || close_grp) begin
      grp_o = new_grp;
    end else if (grows) begin
      grp_o.last_day = item_i.end_day;
      grp_o.last_tag = item_i.end_tag;
    end

    old_res.merged_start     = grp_i.first_day;
    old_res.merged_end       = grp_i.last_day;
    old_res.merged_start_tag = grp_i.first_tag;
    old_res.merged_end_tag   = grp_i.last_tag;
    old_res.last_out         = 1'b0;

    upd_res.merged_start     = grp_o.first_day;
    upd_res.merged_end       = grp_o.last_day;
    upd_res.merged_start_tag = grp_o.first_tag;
    upd_res.merged_end_tag   = grp_o.last_tag;
    upd_res.last_out         = 1'b1;

    // A closed group always goes out first; the flushed group follows it.
    res0_o = close_grp ? old_res : upd_res;
    res1_o = upd_res;
    num_o  = {1'b0, close_grp} + {1'b0, item_i.last_in};

    if (item_i.last_in) begin
      grp_o.open = 1'b0;
    end
  end

endmodule

FILE: sv/drgm_out_fifo.sv
// Three-entry result queue that takes up to two beats per cycle and hands out one.
module drgm_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_num_i,
  input  drgm_pkg::out_item_t push0_i,
  input  drgm_pkg::out_item_t push1_i,
  output logic [drgm_pkg::CntW-1:0] count_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output drgm_pkg::out_item_t out_data_o
);
  import drgm_pkg::*;

  out_item_t       mem_q [FifoD];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_next;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(FifoD - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign wr_next     = ptr_inc(wr_ptr_q);
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    case (push_num_i)
      2'd1:    wr_ptr_d = wr_next;
      2'd2:    wr_ptr_d = ptr_inc(wr_next);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_num_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

endmodule

FILE: sv/date_range_gap_merger.sv
// Top level of the date range gap merger: input register, merge step and result queue.
//
//  Channel | Direction | Handshake           | Beat
//  --------+-----------+---------------------+------------------------------
//  in      | to block  | in_valid_i/in_stall_o   | one date range (in_item_t)
//  out     | from block| out_valid_o/out_stall_i | one merged group (out_item_t)
//  cfg     | to block  | cfg_valid_i/cfg_ready_o | gap_limit write data
//
// A range waits in the input register, is folded into the open group by the merge step,
// and its zero, one or two results go into the three-entry queue as it leaves. One range
// is taken per cycle while there is room; a range that closes a group and also flushes
// yields two beats, so the output side sets the sustained rate when such ranges cluster.
// The merge step runs only while the queue holds at most one beat, so it always has room
// for two; in_stall_o therefore comes from registers alone and never from out_stall_i.
// Reset closes the group, empties both stages and sets gap_limit to zero.
module date_range_gap_merger (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  drgm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output drgm_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [drgm_pkg::GapW-1:0] cfg_data_i
);
  import drgm_pkg::*;

  // Input register.
  in_item_t        in_q;
  logic            in_valid_q, in_valid_d;
  logic            in_accept;
  logic            advance;

  // Group state and gap register.
  group_t          grp_q, grp_d;
  group_t          grp_next;
  logic [GapW-1:0] gap_q;

  // Merge step results.
  out_item_t       res0, res1;
  logic [1:0]      res_num;
  logic [1:0]      push_num;
  logic [CntW-1:0] fifo_cnt;

  // The held range moves on when the queue has space for the worst case of two beats.
  assign advance    = in_valid_q && (fifo_cnt <= CntW'(FifoD - 2));
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    grp_d    = grp_q;
    push_num = 2'd0;
    if (advance) begin
      grp_d    = grp_next;
      push_num = res_num;
    end
  end

  drgm_merge_core u_core (
    .grp_i  (grp_q),
    .item_i (in_q),
    .gap_i  (gap_q),
    .grp_o  (grp_next),
    .res0_o (res0),
    .res1_o (res1),
    .num_o  (res_num)
  );

  drgm_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push0_i     (res0),
    .push1_i     (res1),
    .count_o     (fifo_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      grp_q      <= '0;
      gap_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      grp_q      <= grp_d;
      if (cfg_valid_i && cfg_ready_o) begin
        gap_q <= cfg_data_i;
      end
    end
  end

  // The payload register needs no reset; it is only used while in_valid_q is set.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

endmodule

FILE: test/date_range_gap_merger_check.sv
// Checker that predicts the merged groups of the date range gap merger and compares each beat.
`timescale 1ns / 100ps
module date_range_gap_merger_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  drgm_pkg::in_item_t        in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  drgm_pkg::out_item_t       out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [drgm_pkg::GapW-1:0] cfg_data_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               pending_groups_o,
  output int unsigned               ranges_seen_o,
  output int unsigned               groups_seen_o,
  output int unsigned               double_emits_o
);
  import drgm_pkg::*;

  logic [GapW-1:0] gap_limit;
  group_t          open_grp;
  out_item_t       expected_groups[$];
  int unsigned     mismatches = 0;
  int unsigned     ranges = 0;
  int unsigned     groups = 0;
  int unsigned     doubles = 0;

  function automatic out_item_t group_beat(input group_t g, input logic flush);
    out_item_t b;
    b.merged_start     = g.first_day;
    b.merged_end       = g.last_day;
    b.merged_start_tag = g.first_tag;
    b.merged_end_tag   = g.last_tag;
    b.last_out         = flush;
    return b;
  endfunction

  // Folds one accepted range into the open group and queues the groups it emits.
  task automatic fold_range(input in_item_t r);
    longint distance;
    bit     closed;
    closed   = 1'b0;
    // Signed distance from the group's end, wide enough that it never wraps.
    distance = longint'($signed(r.start_day)) - longint'($signed(open_grp.last_day));
    if (open_grp.open && distance <= longint'(gap_limit) + 1) begin
      if ($signed(r.end_day) > $signed(open_grp.last_day)) begin
        open_grp.last_day = r.end_day;
        open_grp.last_tag = r.end_tag;
      end
    end else begin
      if (open_grp.open) begin
        expected_groups.push_back(group_beat(open_grp, 1'b0));
        closed = 1'b1;
      end
      open_grp.open      = 1'b1;
      open_grp.first_day = r.start_day;
      open_grp.last_day  = r.end_day;
      open_grp.first_tag = r.start_tag;
      open_grp.last_tag  = r.end_tag;
    end
    if (r.last_in) begin
      expected_groups.push_back(group_beat(open_grp, 1'b1));
      open_grp.open = 1'b0;
      if (closed) doubles++;
    end
  endtask

  task automatic check_group(input out_item_t got);
    out_item_t want;
    if (expected_groups.size() == 0) begin
      if (mismatches < 10) begin
        $display("%0t: group beat with none expected: start %0d end %0d tags %h/%h last %0b",
                 $realtime, $signed(got.merged_start), $signed(got.merged_end),
                 got.merged_start_tag, got.merged_end_tag, got.last_out);
      end
      mismatches++;
      return;
    end
    want = expected_groups.pop_front();
    if (got.merged_start !== want.merged_start || got.merged_end !== want.merged_end ||
        got.merged_start_tag !== want.merged_start_tag ||
        got.merged_end_tag !== want.merged_end_tag || got.last_out !== want.last_out) begin
      if (mismatches < 10) begin
        $display("%0t: group mismatch, expected start %0d end %0d tags %h/%h last %0b",
                 $realtime, $signed(want.merged_start), $signed(want.merged_end),
                 want.merged_start_tag, want.merged_end_tag, want.last_out);
        $display("%0t:                 actual   start %0d end %0d tags %h/%h last %0b",
                 $realtime, $signed(got.merged_start), $signed(got.merged_end),
                 got.merged_start_tag, got.merged_end_tag, got.last_out);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit = '0;
      open_grp  = '0;
      expected_groups.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) gap_limit = cfg_data_i;
      // Results of a range never leave in the edge that takes it in, so order is free here.
      if (out_valid_i && !out_stall_i) begin
        groups++;
        check_group(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        ranges++;
        fold_range(in_data_i);
      end
    end
    mismatch_count_o <= mismatches;
    pending_groups_o <= expected_groups.size();
    ranges_seen_o    <= ranges;
    groups_seen_o    <= groups;
    double_emits_o   <= doubles;
  end

endmodule

FILE: test/date_range_gap_merger_test.sv
// Testbench top of the date range gap merger: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module date_range_gap_merger_test;
  import drgm_pkg::*;

  // Length of the one long output hold-off that backs the block up into its input.
  localparam int unsigned     HoldCycles = 300;
  localparam int unsigned     PhaseItems = 450;
  localparam logic [GapW-1:0] GapMax     = '1;
  localparam logic [DayW-1:0] DayMin     = 32'h8000_0000;
  localparam logic [DayW-1:0] DayMax     = 32'h7FFF_FFFF;
  localparam logic [TagW-1:0] TagOnes    = '1;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_stall;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [GapW-1:0] cfg_data;

  // Idle rates in percent per cycle; the receiver process reads its own.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;

  // Running end of the well-formed stream the random part builds on.
  longint stream_end;

  int unsigned mismatch_count;
  int unsigned pending_groups;
  int unsigned ranges_seen;
  int unsigned groups_seen;
  int unsigned double_emits;

  date_range_gap_merger i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  date_range_gap_merger_check i_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_groups_o (pending_groups),
    .ranges_seen_o    (ranges_seen),
    .groups_seen_o    (groups_seen),
    .double_emits_o   (double_emits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run must end well inside this; a hang anywhere lands here.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls at the current rate, or one long hold-off on request. The
  // hold-off is counted here so the sender keeps offering ranges while the block fills.
  initial begin
    int unsigned held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk);
          held++;
        end
        hold_request = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic in_item_t range_of(input logic [DayW-1:0] s, input logic [DayW-1:0] e,
                                        input logic [TagW-1:0] st, input logic [TagW-1:0] et,
                                        input logic flush);
    in_item_t r;
    r.start_day = s;
    r.end_day   = e;
    r.start_tag = st;
    r.end_tag   = et;
    r.last_in   = flush;
    return r;
  endfunction

  // Builds the next random range. Most ranges continue a sorted stream whose starts sit
  // around the merge boundary of the given gap limit; the rest are noise with any days.
  function automatic in_item_t make_stream_range(input logic [GapW-1:0] gap);
    in_item_t    r;
    longint      advance;
    longint      start_d;
    longint      end_d;
    int unsigned roll;
    roll = $urandom_range(99);
    case ($urandom_range(7))
      0: r.start_tag = '0;
      1: r.start_tag = TagOnes;
      default: r.start_tag = $urandom;
    endcase
    case ($urandom_range(7))
      0: r.end_tag = '0;
      1: r.end_tag = TagOnes;
      default: r.end_tag = $urandom;
    endcase
    if (roll < 12) begin
      // Noise: any pair of days and either flag, which breaks the running stream.
      r.start_day = $urandom;
      r.end_day   = $urandom;
      r.last_in   = 1'($urandom_range(1));
      stream_end  = longint'($signed(r.end_day));
      return r;
    end
    case ($urandom_range(5))
      0: advance = -longint'($urandom_range(40));
      1: advance = longint'($urandom_range(gap + 1));
      2: advance = longint'(gap) + 1;
      3: advance = longint'(gap) + 2;
      default: advance = longint'(gap) + 2 + longint'($urandom_range(1000));
    endcase
    start_d = stream_end + advance;
    // A few ranges end before they start; the rest span a short stretch.
    if (roll < 18) begin
      end_d = start_d - longint'($urandom_range(10));
    end else begin
      end_d = start_d + longint'($urandom_range(60));
    end
    // Days past the signed range wrap, which gives an occasional unsorted start.
    r.start_day = start_d[DayW-1:0];
    r.end_day   = end_d[DayW-1:0];
    r.last_in   = ($urandom_range(9) == 0);
    if (advance > longint'(gap) + 1 || longint'($signed(r.end_day)) > stream_end) begin
      stream_end = longint'($signed(r.end_day));
    end
    if (r.last_in) begin
      case ($urandom_range(3))
        0: stream_end = 64'sd2147483647 - longint'($urandom_range(3000));
        1: stream_end = -64'sd2147483648 + longint'($urandom_range(100));
        default: stream_end = longint'($signed($urandom));
      endcase
    end
    return r;
  endfunction

  // Offers one range and holds it until the block takes the beat. Valid stays high into
  // the next range unless the sender decides to idle first.
  task automatic send_range(input in_item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every expected group has been seen, then lets the pipeline settle so a
  // range that merged silently is fully folded in before anything else happens.
  task automatic drain_groups();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_groups != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_gap_limit(input logic [GapW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [GapW-1:0] gap, input int unsigned send_pct,
                           input int unsigned recv_pct, input bit with_hold);
    drain_groups();
    write_gap_limit(gap);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_hold) hold_request = 1'b1;
    repeat (PhaseItems) send_range(make_stream_range(gap));
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b0;
    stream_end    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ranges with the gap limit at its reset value of zero, so only overlap or
    // direct adjacency merges.
    send_range(range_of(10, 20, $urandom, $urandom, 1'b0));    // opens the first group
    send_range(range_of(21, 25, $urandom, $urandom, 1'b0));    // adjacent, end grows
    send_range(range_of(22, 23, $urandom, $urandom, 1'b0));    // inside, end tag stays
    send_range(range_of(27, 30, $urandom, $urandom, 1'b0));    // one day apart, closes
    send_range(range_of(27, 30, $urandom, $urandom, 1'b1));    // equal end, flush
    send_range(range_of(5, 5, '0, TagOnes, 1'b1));             // opens and flushes alone
    send_range(range_of(0, 0, TagOnes, '0, 1'b0));
    send_range(range_of(100, 90, $urandom, $urandom, 1'b1));   // closes and flushes at once
    send_range(range_of(DayMin, DayMin, TagOnes, '0, 1'b0));
    send_range(range_of(DayMax, DayMax, '0, TagOnes, 1'b1));   // widest distance
    send_range(range_of(DayMax, DayMin, $urandom, $urandom, 1'b0)); // end before start
    send_range(range_of(DayMin, DayMax, $urandom, $urandom, 1'b1)); // merges against it
    send_range(range_of(1000, 2000, $urandom, $urandom, 1'b0));
    send_range(range_of(-5, 1500, $urandom, $urandom, 1'b0));  // unsorted start merges
    send_range(range_of(DayMin, DayMax, $urandom, $urandom, 1'b1));
    send_range(range_of(-1, -1, $urandom, $urandom, 1'b0));
    send_range(range_of(0, 5, $urandom, $urandom, 1'b1));      // adjacent across zero

    // The widest gap limit: a start exactly gap_limit + 1 past the end still merges.
    drain_groups();
    write_gap_limit(GapMax);
    send_range(range_of(0, 0, $urandom, $urandom, 1'b0));
    send_range(range_of(32'd1048576, 10, $urandom, $urandom, 1'b0));
    send_range(range_of(32'd1048588, 20, $urandom, $urandom, 1'b1));
    send_range(range_of(DayMin, DayMin, $urandom, $urandom, 1'b0));
    send_range(range_of(DayMax, DayMax, $urandom, $urandom, 1'b1));

    // Random phases: sender idles less than the receiver, then the reverse with the long
    // output hold-off at its start, then both run flat out.
    run_phase(GapW'($urandom_range(40, 2)), 29, 48, 1'b0);
    run_phase(GapMax, 48, 29, 1'b1);
    run_phase('0, 0, 0, 1'b0);
    drain_groups();

    $display("Merged %0d date ranges into %0d groups; %0d ranges closed a group and flushed.",
             ranges_seen, groups_seen, double_emits);
    $display("Gap limits went from zero to the widest, under mixed idling and a long hold-off.");
    if (mismatch_count == 0 && pending_groups == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
